>>> rtl/fdtd_pkg.sv
// ----------------------------------------------------------------------------
// fdtd_pkg
// Shared constants for the Yee grid update block: grid defaults, word width,
// item kinds and array selector codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fdtd_pkg;

    localparam int GRID_X_DEF = 16;
    localparam int GRID_Y_DEF = 16;
    localparam int GRID_Z_DEF = 16;

    localparam int DATA_W     = 32;
    localparam int NUM_ARRAYS = 12;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_ESTEP = 2'd2;
    localparam logic [1:0] KIND_HSTEP = 2'd3;

    localparam int SEL_E_FIELD = 0;
    localparam int SEL_H_FIELD = 3;
    localparam int SEL_E_COEF  = 6;
    localparam int SEL_H_COEF  = 9;

    typedef logic signed [DATA_W-1:0] word_t;

endpackage

`default_nettype wire

>>> rtl/fdtd_mem.sv
// ----------------------------------------------------------------------------
// fdtd_mem
// Single-clock word memory, one write port and one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fdtd_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire                  clk,
    input  wire                  we,
    input  wire [AW-1:0]         waddr,
    input  fdtd_pkg::word_t      wdata,
    input  wire [AW-1:0]         raddr,
    output fdtd_pkg::word_t      rdata
);

    fdtd_pkg::word_t mem [0:DEPTH-1];
    fdtd_pkg::word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/fdtd_upd.sv
// ----------------------------------------------------------------------------
// fdtd_upd
// Field component update: curl, Q16.16 product truncated toward minus
// infinity, saturating accumulate. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fdtd_upd (
    input  wire                  clk,
    input  wire                  neg,
    input  fdtd_pkg::word_t      field,
    input  fdtd_pkg::word_t      coef,
    input  fdtd_pkg::word_t      p1,
    input  fdtd_pkg::word_t      m1,
    input  fdtd_pkg::word_t      p2,
    input  fdtd_pkg::word_t      m2,
    output fdtd_pkg::word_t      result
);

    logic signed [33:0] diff;
    logic signed [34:0] curl_reg;
    logic signed [34:0] curl_next;
    fdtd_pkg::word_t    field1_reg;
    fdtd_pkg::word_t    coef1_reg;
    logic               neg1_reg;
    logic signed [66:0] prod_reg;
    fdtd_pkg::word_t    field2_reg;
    logic               neg2_reg;
    logic signed [50:0] quot;
    logic signed [52:0] sum;

    assign diff = (34'(p1) - 34'(m1)) - (34'(p2) - 34'(m2));
    assign curl_next = neg ? -35'(diff) : 35'(diff);

    always_ff @(posedge clk)
    begin
        curl_reg   <= curl_next;
        field1_reg <= field;
        coef1_reg  <= coef;
        neg1_reg   <= neg;
        prod_reg   <= 67'(coef1_reg) * 67'(curl_reg);
        field2_reg <= field1_reg;
        neg2_reg   <= neg1_reg;
    end

    assign quot = prod_reg[66:16];
    assign sum  = neg2_reg ? (53'(field2_reg) - 53'(quot)) : (53'(field2_reg) + 53'(quot));

    always_comb
    begin
        if (sum[52:31] == '0 || sum[52:31] == '1)
        begin
            result = sum[31:0];
        end
        else if (sum[52])
        begin
            result = {1'b1, 31'd0};
        end
        else
        begin
            result = {1'b0, {31{1'b1}}};
        end
    end

endmodule

`default_nettype wire

>>> rtl/fdtd_yee_grid_update_top.sv
// ----------------------------------------------------------------------------
// fdtd_yee_grid_update_top
// 3D Yee grid leapfrog update over twelve on-chip word memories.
//
// Input channel (in_valid/in_stall) carries one item per transfer: word write,
// word read, electric half-step or magnetic half-step. Output channel
// (out_valid/out_stall) returns exactly one result per item, in order.
// Only one item is in work at a time; in_stall is low while the sequencer
// is idle, also while a finished result still waits in the output register.
// A write result passes through the finish state into the output register,
// a read result through the read-wait and finish states; the next item is
// taken once the sequencer is back in idle. A half-step walks the cells one
// at a time (three reads of the neighbour memory port, then the two-stage
// multiply and write back); its result follows the write back of the last
// cell. After reset the block sweeps all memories to zero, one cell per
// cycle, with in_stall held high.
// A stalled receiver holds the result in the output register; the next
// item is still taken, and its result waits until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module fdtd_yee_grid_update_top #(
    parameter int GRID_X = fdtd_pkg::GRID_X_DEF,
    parameter int GRID_Y = fdtd_pkg::GRID_Y_DEF,
    parameter int GRID_Z = fdtd_pkg::GRID_Z_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire  [1:0]           kind,
    input  wire  [3:0]           array_sel,
    input  wire  [3:0]           pos_x,
    input  wire  [3:0]           pos_y,
    input  wire  [3:0]           pos_z,
    input  wire  signed [31:0]   write_value,
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic signed [31:0]   read_value,
    output logic [1:0]           done_kind
);

    localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int ZW    = $clog2(GRID_Z);
    localparam int NA    = fdtd_pkg::NUM_ARRAYS;

    localparam logic [AW-1:0] STRIDE_Z = AW'(1);
    localparam logic [AW-1:0] STRIDE_Y = AW'(GRID_Z);
    localparam logic [AW-1:0] STRIDE_X = AW'(GRID_Y * GRID_Z);
    localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
    localparam logic [XW-1:0] LAST_X   = XW'(GRID_X - 1);
    localparam logic [YW-1:0] LAST_Y   = YW'(GRID_Y - 1);
    localparam logic [ZW-1:0] LAST_Z   = ZW'(GRID_Z - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_STEP   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [2:0] PH_LAST = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [2:0]          ph_reg;
    logic [AW-1:0]       a_reg;
    logic [XW-1:0]       x_reg;
    logic [YW-1:0]       y_reg;
    logic [ZW-1:0]       z_reg;
    logic                hstep_reg;
    logic [3:0]          rd_sel_reg;
    logic                rd_ok_reg;
    logic [1:0]          res_kind_reg;
    fdtd_pkg::word_t     res_value_reg;
    logic                out_valid_reg;
    fdtd_pkg::word_t     read_value_reg;
    logic [1:0]          done_kind_reg;

    logic                accept;
    logic                pos_in;
    logic                sel_ok;
    logic [AW-1:0]       in_addr;
    logic                nx, ny, nz;
    logic                step_wr;

    logic [AW-1:0]       mem_waddr;
    logic                mem_we    [0:NA-1];
    fdtd_pkg::word_t     mem_wdata [0:NA-1];
    logic [AW-1:0]       mem_raddr [0:NA-1];
    fdtd_pkg::word_t     mem_rdata [0:NA-1];

    logic [AW-1:0]       nba_addr [0:2];
    logic [AW-1:0]       nbb_addr [0:2];
    logic [AW-1:0]       src_addr [0:2];
    logic                va [0:2];
    logic                vb [0:2];
    logic                wen [0:2];
    fdtd_pkg::word_t     src_data [0:2];
    fdtd_pkg::word_t     src_reg  [0:2];
    fdtd_pkg::word_t     dst_reg  [0:2];
    fdtd_pkg::word_t     coef_reg [0:2];
    fdtd_pkg::word_t     nba_reg  [0:2];
    fdtd_pkg::word_t     nbb_reg  [0:2];
    fdtd_pkg::word_t     upd_res  [0:2];

    assign accept  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign pos_in  = (int'(pos_x) < GRID_X) && (int'(pos_y) < GRID_Y)
                     && (int'(pos_z) < GRID_Z);
    assign sel_ok  = (int'(array_sel) < NA);
    assign in_addr = AW'((int'(pos_x) * GRID_Y + int'(pos_y)) * GRID_Z + int'(pos_z));

    assign nx = hstep_reg ? (x_reg != '0) : (x_reg != LAST_X);
    assign ny = hstep_reg ? (y_reg != '0) : (y_reg != LAST_Y);
    assign nz = hstep_reg ? (z_reg != '0) : (z_reg != LAST_Z);

    assign step_wr = (state_reg == ST_STEP) && (ph_reg == PH_LAST);

    assign va[0] = nz;
    assign va[1] = nz;
    assign va[2] = ny;
    assign vb[0] = ny;
    assign vb[1] = nx;
    assign vb[2] = nx;
    assign wen[0] = ny;
    assign wen[1] = nx;
    assign wen[2] = nx && ny;

    assign nba_addr[0] = hstep_reg ? (a_reg - STRIDE_Z) : (a_reg + STRIDE_Z);
    assign nba_addr[1] = hstep_reg ? (a_reg - STRIDE_Z) : (a_reg + STRIDE_Z);
    assign nba_addr[2] = hstep_reg ? (a_reg - STRIDE_Y) : (a_reg + STRIDE_Y);
    assign nbb_addr[0] = hstep_reg ? (a_reg - STRIDE_Y) : (a_reg + STRIDE_Y);
    assign nbb_addr[1] = hstep_reg ? (a_reg - STRIDE_X) : (a_reg + STRIDE_X);
    assign nbb_addr[2] = hstep_reg ? (a_reg - STRIDE_X) : (a_reg + STRIDE_X);

    assign mem_waddr = (state_reg == ST_IDLE) ? in_addr : a_reg;

    genvar c;
    generate
        for (c = 0; c < 3; c++)
        begin : g_comp
            localparam int IE  = fdtd_pkg::SEL_E_FIELD + c;
            localparam int IH  = fdtd_pkg::SEL_H_FIELD + c;
            localparam int ICE = fdtd_pkg::SEL_E_COEF + c;
            localparam int ICH = fdtd_pkg::SEL_H_COEF + c;
            logic item_wr_e, item_wr_h, item_wr_ce, item_wr_ch;
            logic clr;

            assign clr = (state_reg == ST_CLEAR);
            assign item_wr_e  = accept && (kind == fdtd_pkg::KIND_WRITE) && pos_in
                                && (array_sel == 4'(IE));
            assign item_wr_h  = accept && (kind == fdtd_pkg::KIND_WRITE) && pos_in
                                && (array_sel == 4'(IH));
            assign item_wr_ce = accept && (kind == fdtd_pkg::KIND_WRITE) && pos_in
                                && (array_sel == 4'(ICE));
            assign item_wr_ch = accept && (kind == fdtd_pkg::KIND_WRITE) && pos_in
                                && (array_sel == 4'(ICH));

            assign src_addr[c] = (ph_reg == 3'd1) ? nba_addr[c] :
                                 (ph_reg == 3'd2) ? nbb_addr[c] : a_reg;
            assign src_data[c] = hstep_reg ? mem_rdata[IE] : mem_rdata[IH];

            always_comb
            begin
                if (state_reg == ST_STEP)
                begin
                    mem_raddr[IE]  = hstep_reg ? src_addr[c] : a_reg;
                    mem_raddr[IH]  = hstep_reg ? a_reg : src_addr[c];
                    mem_raddr[ICE] = a_reg;
                    mem_raddr[ICH] = a_reg;
                end
                else
                begin
                    mem_raddr[IE]  = in_addr;
                    mem_raddr[IH]  = in_addr;
                    mem_raddr[ICE] = in_addr;
                    mem_raddr[ICH] = in_addr;
                end
            end

            assign mem_we[IE]  = clr || item_wr_e || (step_wr && !hstep_reg && wen[c]);
            assign mem_we[IH]  = clr || item_wr_h || (step_wr && hstep_reg && wen[c]);
            assign mem_we[ICE] = clr || item_wr_ce;
            assign mem_we[ICH] = clr || item_wr_ch;

            assign mem_wdata[IE]  = clr ? '0 : (state_reg == ST_STEP) ? upd_res[c] : write_value;
            assign mem_wdata[IH]  = clr ? '0 : (state_reg == ST_STEP) ? upd_res[c] : write_value;
            assign mem_wdata[ICE] = clr ? '0 : write_value;
            assign mem_wdata[ICH] = clr ? '0 : write_value;

            always_ff @(posedge clk)
            begin
                if (state_reg == ST_STEP)
                begin
                    if (ph_reg == 3'd1)
                    begin
                        src_reg[c]  <= src_data[c];
                        dst_reg[c]  <= hstep_reg ? mem_rdata[IH] : mem_rdata[IE];
                        coef_reg[c] <= hstep_reg ? mem_rdata[ICH] : mem_rdata[ICE];
                    end
                    if (ph_reg == 3'd2)
                    begin
                        nba_reg[c] <= va[c] ? src_data[c] : '0;
                    end
                    if (ph_reg == 3'd3)
                    begin
                        nbb_reg[c] <= vb[c] ? src_data[c] : '0;
                    end
                end
            end
        end

        for (c = 0; c < NA; c++)
        begin : g_mem
            fdtd_mem #(
                .DEPTH (CELLS),
                .AW    (AW)
            ) u_mem (
                .clk   (clk),
                .we    (mem_we[c]),
                .waddr (mem_waddr),
                .wdata (mem_wdata[c]),
                .raddr (mem_raddr[c]),
                .rdata (mem_rdata[c])
            );
        end
    endgenerate

    fdtd_upd u_upd_x (
        .clk    (clk),
        .neg    (hstep_reg),
        .field  (dst_reg[0]),
        .coef   (coef_reg[0]),
        .p1     (nba_reg[2]),
        .m1     (src_reg[2]),
        .p2     (nba_reg[1]),
        .m2     (src_reg[1]),
        .result (upd_res[0])
    );

    fdtd_upd u_upd_y (
        .clk    (clk),
        .neg    (hstep_reg),
        .field  (dst_reg[1]),
        .coef   (coef_reg[1]),
        .p1     (nba_reg[0]),
        .m1     (src_reg[0]),
        .p2     (nbb_reg[2]),
        .m2     (src_reg[2]),
        .result (upd_res[1])
    );

    fdtd_upd u_upd_z (
        .clk    (clk),
        .neg    (hstep_reg),
        .field  (dst_reg[2]),
        .coef   (coef_reg[2]),
        .p1     (nbb_reg[1]),
        .m1     (src_reg[1]),
        .p2     (nbb_reg[0]),
        .m2     (src_reg[0]),
        .result (upd_res[2])
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (a_reg == LAST_A)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        fdtd_pkg::KIND_READ:  state_next = ST_RDWAIT;
                        fdtd_pkg::KIND_ESTEP: state_next = ST_STEP;
                        fdtd_pkg::KIND_HSTEP: state_next = ST_STEP;
                        default:              state_next = ST_FINISH;
                    endcase
                end
            end
            ST_RDWAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_STEP:
            begin
                if (step_wr && a_reg == LAST_A)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ph_reg        <= '0;
            a_reg         <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            hstep_reg     <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    a_reg <= (a_reg == LAST_A) ? '0 : a_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        hstep_reg <= (kind == fdtd_pkg::KIND_HSTEP);
                        rd_ok_reg <= pos_in && sel_ok;
                        ph_reg    <= '0;
                        a_reg     <= '0;
                        x_reg     <= '0;
                        y_reg     <= '0;
                        z_reg     <= '0;
                    end
                end
                ST_STEP:
                begin
                    if (ph_reg == PH_LAST)
                    begin
                        ph_reg <= '0;
                        a_reg  <= (a_reg == LAST_A) ? '0 : a_reg + 1'b1;
                        if (z_reg == LAST_Z)
                        begin
                            z_reg <= '0;
                            if (y_reg == LAST_Y)
                            begin
                                y_reg <= '0;
                                x_reg <= (x_reg == LAST_X) ? '0 : x_reg + 1'b1;
                            end
                            else
                            begin
                                y_reg <= y_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            z_reg <= z_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end
                default:
                begin
                    ph_reg <= ph_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_kind_reg  <= kind;
            res_value_reg <= '0;
            rd_sel_reg    <= array_sel;
        end
        if (state_reg == ST_RDWAIT)
        begin
            res_value_reg <= rd_ok_reg ? mem_rdata[rd_sel_reg] : '0;
        end
        if (state_reg == ST_FINISH && (!out_valid_reg || !out_stall))
        begin
            read_value_reg <= res_value_reg;
            done_kind_reg  <= res_kind_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign done_kind  = done_kind_reg;

`ifndef SYNTHESIS
    a_ph_range: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg <= PH_LAST)
        else $error("phase counter out of range");

    a_step_write_last_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && ph_reg != PH_LAST)
        |-> !(mem_we[fdtd_pkg::SEL_E_FIELD] || mem_we[fdtd_pkg::SEL_H_FIELD]))
        else $error("field write outside write-back phase");

    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_kind != fdtd_pkg::KIND_READ) |-> (read_value == '0))
        else $error("non-read result carries data");

    a_clear_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !accept)
        else $error("transfer taken during memory clear");
`endif

endmodule

`default_nettype wire

>>> dv/fdtd_yee_grid_update_top_tb.sv
// ----------------------------------------------------------------------------
// fdtd_yee_grid_update_top_tb
// Self-checking bench for the Yee grid update block. A local copy of the
// twelve grid arrays predicts every read and every half-step; each result is
// compared in order against the queued expectation. Stimulus is a directed
// pass followed by random word accesses with occasional half-steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class fdtd_scoreboard;
    localparam int NX = 16;
    localparam int NY = 16;
    localparam int NZ = 16;
    localparam int NC = NX * NY * NZ;

    localparam int EX  = fdtd_pkg::SEL_E_FIELD;
    localparam int EY  = fdtd_pkg::SEL_E_FIELD + 1;
    localparam int EZ  = fdtd_pkg::SEL_E_FIELD + 2;
    localparam int HX  = fdtd_pkg::SEL_H_FIELD;
    localparam int HY  = fdtd_pkg::SEL_H_FIELD + 1;
    localparam int HZ  = fdtd_pkg::SEL_H_FIELD + 2;
    localparam int CEX = fdtd_pkg::SEL_E_COEF;
    localparam int CEY = fdtd_pkg::SEL_E_COEF + 1;
    localparam int CEZ = fdtd_pkg::SEL_E_COEF + 2;
    localparam int CHX = fdtd_pkg::SEL_H_COEF;
    localparam int CHY = fdtd_pkg::SEL_H_COEF + 1;
    localparam int CHZ = fdtd_pkg::SEL_H_COEF + 2;

    logic signed [31:0] grid [fdtd_pkg::NUM_ARRAYS][NC];
    logic signed [31:0] exp_value [$];
    logic [1:0]         exp_kind [$];
    int                 errors;

    function new();
        errors = 0;
        foreach (grid[a, c])
            grid[a][c] = '0;
    endfunction

    function automatic int cell_addr(int x, int y, int z);
        return (x * NY + y) * NZ + z;
    endfunction

    function automatic longint fetch(int a, int x, int y, int z);
        if (x < 0 || x >= NX || y < 0 || y >= NY || z < 0 || z >= NZ)
            return 0;
        return longint'(grid[a][cell_addr(x, y, z)]);
    endfunction

    function automatic longint coef_mul(logic signed [31:0] coef, longint curl);
        longint p;
        p = longint'(coef) * curl;
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic void update_at(int f, int co, int c, longint curl, bit sub);
        longint d;
        d = coef_mul(grid[co][c], curl);
        grid[f][c] = clamp(longint'(grid[f][c]) + (sub ? -d : d));
    endfunction

    function automatic void electric_sweep();
        int c;
        longint cu;
        for (int x = 0; x < NX; x++)
            for (int y = 0; y < NY; y++)
                for (int z = 0; z < NZ; z++)
                begin
                    c = cell_addr(x, y, z);
                    if (y < NY - 1)
                    begin
                        cu = (fetch(HZ, x, y + 1, z) - fetch(HZ, x, y, z))
                           - (fetch(HY, x, y, z + 1) - fetch(HY, x, y, z));
                        update_at(EX, CEX, c, cu, 0);
                    end
                    if (x < NX - 1)
                    begin
                        cu = (fetch(HX, x, y, z + 1) - fetch(HX, x, y, z))
                           - (fetch(HZ, x + 1, y, z) - fetch(HZ, x, y, z));
                        update_at(EY, CEY, c, cu, 0);
                    end
                    if (x < NX - 1 && y < NY - 1)
                    begin
                        cu = (fetch(HY, x + 1, y, z) - fetch(HY, x, y, z))
                           - (fetch(HX, x, y + 1, z) - fetch(HX, x, y, z));
                        update_at(EZ, CEZ, c, cu, 0);
                    end
                end
    endfunction

    function automatic void magnetic_sweep();
        int c;
        longint cu;
        for (int x = 0; x < NX; x++)
            for (int y = 0; y < NY; y++)
                for (int z = 0; z < NZ; z++)
                begin
                    c = cell_addr(x, y, z);
                    if (y >= 1)
                    begin
                        cu = (fetch(EZ, x, y, z) - fetch(EZ, x, y - 1, z))
                           - (fetch(EY, x, y, z) - fetch(EY, x, y, z - 1));
                        update_at(HX, CHX, c, cu, 1);
                    end
                    if (x >= 1)
                    begin
                        cu = (fetch(EX, x, y, z) - fetch(EX, x, y, z - 1))
                           - (fetch(EZ, x, y, z) - fetch(EZ, x - 1, y, z));
                        update_at(HY, CHY, c, cu, 1);
                    end
                    if (x >= 1 && y >= 1)
                    begin
                        cu = (fetch(EY, x, y, z) - fetch(EY, x - 1, y, z))
                           - (fetch(EX, x, y, z) - fetch(EX, x, y - 1, z));
                        update_at(HZ, CHZ, c, cu, 1);
                    end
                end
    endfunction

    function automatic void note_item(logic [1:0] k, logic [3:0] sel, logic [3:0] px,
                                      logic [3:0] py, logic [3:0] pz,
                                      logic signed [31:0] wv);
        logic signed [31:0] rd;
        rd = '0;
        case (k)
            fdtd_pkg::KIND_WRITE:
                if (sel < fdtd_pkg::NUM_ARRAYS)
                    grid[sel][cell_addr(px, py, pz)] = wv;
            fdtd_pkg::KIND_READ:
                if (sel < fdtd_pkg::NUM_ARRAYS)
                    rd = grid[sel][cell_addr(px, py, pz)];
            fdtd_pkg::KIND_ESTEP: electric_sweep();
            default:              magnetic_sweep();
        endcase
        exp_value.push_back(rd);
        exp_kind.push_back(k);
    endfunction

    function automatic void check_result(logic signed [31:0] rv, logic [1:0] dk);
        logic signed [31:0] ev;
        logic [1:0]         ek;
        if (exp_value.size() == 0)
        begin
            $display("%0t: unexpected transfer read_value=%h done_kind=%0d", $time, rv, dk);
            errors++;
            return;
        end
        ev = exp_value.pop_front();
        ek = exp_kind.pop_front();
        if (rv !== ev)
        begin
            $display("%0t: read_value expected %h actual %h", $time, ev, rv);
            errors++;
        end
        if (dk !== ek)
        begin
            $display("%0t: done_kind expected %0d actual %0d", $time, ek, dk);
            errors++;
        end
    endfunction
endclass

module fdtd_yee_grid_update_top_tb;

    localparam longint CYCLE_LIMIT = 2_000_000;

    localparam logic [3:0] S_EX  = 4'(fdtd_pkg::SEL_E_FIELD);
    localparam logic [3:0] S_EZ  = 4'(fdtd_pkg::SEL_E_FIELD + 2);
    localparam logic [3:0] S_HX  = 4'(fdtd_pkg::SEL_H_FIELD);
    localparam logic [3:0] S_HY  = 4'(fdtd_pkg::SEL_H_FIELD + 1);
    localparam logic [3:0] S_HZ  = 4'(fdtd_pkg::SEL_H_FIELD + 2);
    localparam logic [3:0] S_CEX = 4'(fdtd_pkg::SEL_E_COEF);
    localparam logic [3:0] S_CEY = 4'(fdtd_pkg::SEL_E_COEF + 1);
    localparam logic [3:0] S_CEZ = 4'(fdtd_pkg::SEL_E_COEF + 2);
    localparam logic [3:0] S_CHX = 4'(fdtd_pkg::SEL_H_COEF);
    localparam logic [3:0] S_CHY = 4'(fdtd_pkg::SEL_H_COEF + 1);
    localparam logic [3:0] S_CHZ = 4'(fdtd_pkg::SEL_H_COEF + 2);

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic [3:0]         array_sel;
    logic [3:0]         pos_x;
    logic [3:0]         pos_y;
    logic [3:0]         pos_z;
    logic signed [31:0] write_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] read_value;
    logic [1:0]         done_kind;

    fdtd_scoreboard grid_sb;
    bit             quiet;
    longint         cycles;

    fdtd_yee_grid_update_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .array_sel   (array_sel),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .done_kind   (done_kind)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            grid_sb.check_result(read_value, done_kind);
    end

    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge clk);
        while (1)
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    task automatic send_item(logic [1:0] k, logic [3:0] sel, logic [3:0] px,
                             logic [3:0] py, logic [3:0] pz, logic signed [31:0] wv);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        array_sel   <= sel;
        pos_x       <= px;
        pos_y       <= py;
        pos_z       <= pz;
        write_value <= wv;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        grid_sb.note_item(k, sel, px, py, pz, wv);
    endtask

    task automatic send_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        send_idle();
        while (grid_sb.exp_value.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return $urandom_range(0, 32'h0003ffff);
            3:       return -$urandom_range(0, 32'h0003ffff);
            default: return $urandom();
        endcase
    endfunction

    task automatic rand_access(bit focus);
        logic [1:0] k;
        logic [3:0] s;
        k = $urandom_range(0, 1) ? fdtd_pkg::KIND_WRITE : fdtd_pkg::KIND_READ;
        s = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
                                          : 4'($urandom_range(0, 11));
        if (focus)
            send_item(k, s, 4'($urandom_range(0, 2)), 4'($urandom_range(0, 2)),
                      4'($urandom_range(0, 2)), rand_word());
        else
            send_item(k, s, 4'($urandom()), 4'($urandom()), 4'($urandom()), rand_word());
    endtask

    initial
    begin
        grid_sb     = new();
        quiet       = 1'b0;
        cycles      = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = fdtd_pkg::KIND_WRITE;
        array_sel   = '0;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        write_value = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_item(fdtd_pkg::KIND_READ, S_EX, 0, 0, 0, 0);
        send_item(fdtd_pkg::KIND_WRITE, S_CEX, 0, 0, 0, 32'h7fffffff);
        send_item(fdtd_pkg::KIND_WRITE, S_HZ, 0, 1, 0, 32'h7fffffff);
        send_item(fdtd_pkg::KIND_WRITE, S_HZ, 0, 0, 0, 32'h80000000);
        send_item(fdtd_pkg::KIND_WRITE, S_EX, 0, 0, 0, 32'h7fff0000);
        send_item(fdtd_pkg::KIND_WRITE, S_CEY, 15, 15, 15, 32'h80000000);
        send_item(fdtd_pkg::KIND_WRITE, S_CEZ, 14, 14, 15, 32'hffff8000);
        send_item(fdtd_pkg::KIND_WRITE, S_HY, 15, 14, 15, 32'h00010000);
        send_item(fdtd_pkg::KIND_WRITE, S_CHX, 0, 1, 0, 32'h00010000);
        send_item(fdtd_pkg::KIND_WRITE, S_CHY, 1, 0, 0, 32'hffff0001);
        send_item(fdtd_pkg::KIND_WRITE, S_CHZ, 15, 15, 15, 32'h00008000);
        send_item(fdtd_pkg::KIND_WRITE, S_EZ, 0, 1, 0, 32'h80000001);
        send_item(fdtd_pkg::KIND_WRITE, 4'd12, 1, 1, 1, 32'h12345678);
        send_item(fdtd_pkg::KIND_WRITE, 4'd15, 15, 15, 15, 32'hffffffff);
        send_item(fdtd_pkg::KIND_READ, 4'd15, 15, 15, 15, 0);
        send_item(fdtd_pkg::KIND_READ, S_CHZ, 15, 15, 15, 0);
        send_item(fdtd_pkg::KIND_ESTEP, 4'd15, 15, 15, 15, 32'hffffffff);
        send_item(fdtd_pkg::KIND_READ, S_EX, 0, 0, 0, 0);
        send_item(fdtd_pkg::KIND_READ, S_EZ, 14, 14, 15, 0);
        send_item(fdtd_pkg::KIND_HSTEP, S_EX, 0, 0, 0, 0);
        send_item(fdtd_pkg::KIND_READ, S_HX, 0, 1, 0, 0);
        send_item(fdtd_pkg::KIND_READ, S_HY, 1, 0, 0, 0);
        drain();

        for (int i = 0; i < 100; i++)
        begin
            if (i > 85)
                quiet = 1'b1;
            if (i % 25 == 24)
                send_item($urandom_range(0, 1) ? fdtd_pkg::KIND_ESTEP : fdtd_pkg::KIND_HSTEP,
                          4'($urandom()), 4'($urandom()), 4'($urandom()), 4'($urandom()),
                          $urandom());
            else
                rand_access($urandom_range(0, 2) != 0);
            if (i == 50)
                drain();
        end

        drain();
        repeat (50) @(posedge clk);
        if (grid_sb.errors == 0 && grid_sb.exp_value.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/fdtd_pkg.sv
rtl/fdtd_mem.sv
rtl/fdtd_upd.sv
rtl/fdtd_yee_grid_update_top.sv
dv/fdtd_yee_grid_update_top_tb.sv
